[design/btls_pkg.sv]
// Package: constants, register codes and reset values for the burst triggered light switch.
`timescale 1ns / 1ps
`default_nettype none
package btls_pkg;

    localparam int CHANNELS_DEF     = 4;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int TS_W     = 31;
    localparam int DELAY_W  = 12;
    localparam int CFG_W    = 16;
    localparam int RUN_W    = 17;
    localparam int TIME_W   = 33;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int OUT_W    = 8;

    localparam logic [RUN_W-1:0]         RUN_MAX = RUN_W'(65536);
    localparam logic signed [TIME_W-1:0] NO_TIME = -TIME_W'(1);

    localparam logic [CFG_W-1:0] THRESHOLD_RST    = '0;
    localparam logic [CFG_W-1:0] WINDOW_COUNT_RST = CFG_W'(100);
    localparam logic [CFG_W-1:0] LIGHT_TICKS_RST  = CFG_W'(200);
    localparam logic [CFG_W-1:0] IGNORE_TICKS_RST = CFG_W'(1000);
    localparam logic [CFG_W-1:0] CLEAR_TICKS_RST  = CFG_W'(2000);

    typedef enum logic [2:0] {
        REG_THRESHOLD    = 3'd0,
        REG_WINDOW_COUNT = 3'd1,
        REG_LIGHT_TICKS  = 3'd2,
        REG_IGNORE_TICKS = 3'd3,
        REG_CLEAR_TICKS  = 3'd4,
        REG_DELAY_ENABLE = 3'd5
    } cfg_reg_t;

endpackage
`default_nettype wire

[design/burst_triggered_light_switch.sv]
// Top level: run counting, crossing latch and light timing in one registered pass.
//
// Each accepted word is held in an input register, all per-channel threshold compares,
// run counts and timer checks are evaluated in one pass of short logic, and the result
// word is loaded into the output register once that register is free, so a new word
// can be accepted every cycle while the output is not stalled. The output register
// decouples the two sides: the input register keeps taking words while the output is
// free or being taken in the same cycle. A clear word (tuser high) resets all run
// counts, the latch, the light and the timers and opens a window of clear_ticks during
// which crossings are ignored; its result is all zero.
`timescale 1ns / 1ps
`default_nettype none
module burst_triggered_light_switch #(
    parameter int CHANNELS     = btls_pkg::CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = btls_pkg::SAMPLE_WIDTH_DEF,
    parameter int S_TDATA_W    = ((btls_pkg::TS_W + CHANNELS * SAMPLE_WIDTH
                                   + btls_pkg::DELAY_W + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // tdata: timestamp, sample_0 .. sample_{CHANNELS-1}, delay_ticks, zero pad
    input  wire logic [S_TDATA_W-1:0]          s_tdata,
    // tuser: action (0 sample, 1 clear)
    input  wire logic                          s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata: light_on, crossing_latched, any_crossing, zero pad
    output logic [btls_pkg::OUT_W-1:0]         m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [btls_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [btls_pkg::PDATA_W-1:0]  pwdata,
    output logic [btls_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import btls_pkg::*;

    localparam int CMP_W    = (SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W;
    localparam int DELAY_LO = TS_W + CHANNELS * SAMPLE_WIDTH;

    // configuration
    logic [CFG_W-1:0] threshold_reg, window_reg, light_ticks_reg;
    logic [CFG_W-1:0] ignore_ticks_reg, clear_ticks_reg;
    logic             delay_en_reg;
    logic             cfg_wr;

    // input register
    logic                           in_valid_reg, in_valid_next;
    logic                           in_action_reg;
    logic [TS_W-1:0]                in_ts_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg [CHANNELS];
    logic [DELAY_W-1:0]             in_delay_reg;

    // state
    logic [RUN_W-1:0]         run_reg [CHANNELS];
    logic [RUN_W-1:0]         run_next [CHANNELS];
    logic                     latch_reg, latch_next;
    logic                     light_reg, light_next;
    logic signed [TIME_W-1:0] light_off_reg, light_off_next;
    logic signed [TIME_W-1:0] ignore_until_reg, ignore_until_next;
    logic signed [TIME_W-1:0] clear_until_reg, clear_until_next;
    logic signed [TIME_W-1:0] fire_reg, fire_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic                     out_free, proc, any_cross, ok;
    logic signed [TIME_W-1:0] ts, delay_t;
    logic signed [CMP_W-1:0]  thr_x, samp_x;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RST;
            window_reg       <= WINDOW_COUNT_RST;
            light_ticks_reg  <= LIGHT_TICKS_RST;
            ignore_ticks_reg <= IGNORE_TICKS_RST;
            clear_ticks_reg  <= CLEAR_TICKS_RST;
            delay_en_reg     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_reg_t'(paddr[4:2]))
                REG_THRESHOLD:    threshold_reg    <= pwdata[CFG_W-1:0];
                REG_WINDOW_COUNT: window_reg       <= pwdata[CFG_W-1:0];
                REG_LIGHT_TICKS:  light_ticks_reg  <= pwdata[CFG_W-1:0];
                REG_IGNORE_TICKS: ignore_ticks_reg <= pwdata[CFG_W-1:0];
                REG_CLEAR_TICKS:  clear_ticks_reg  <= pwdata[CFG_W-1:0];
                REG_DELAY_ENABLE: delay_en_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg_t'(paddr[4:2]))
            REG_THRESHOLD:    prdata = {{(PDATA_W-CFG_W){threshold_reg[CFG_W-1]}},
                                        threshold_reg};
            REG_WINDOW_COUNT: prdata = PDATA_W'(window_reg);
            REG_LIGHT_TICKS:  prdata = PDATA_W'(light_ticks_reg);
            REG_IGNORE_TICKS: prdata = PDATA_W'(ignore_ticks_reg);
            REG_CLEAR_TICKS:  prdata = PDATA_W'(clear_ticks_reg);
            REG_DELAY_ENABLE: prdata = PDATA_W'(delay_en_reg);
            default:          prdata = '0;
        endcase
    end

    // handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (proc) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_ts_reg     <= s_tdata[TS_W-1:0];
            in_delay_reg  <= s_tdata[DELAY_LO +: DELAY_W];
            for (int i = 0; i < CHANNELS; i++) begin
                in_sample_reg[i] <= s_tdata[TS_W + i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            end
        end
        if (proc) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // one pass over the held word
    always_comb begin
        ts      = $signed({2'b00, in_ts_reg});
        delay_t = $signed({{(TIME_W-DELAY_W){1'b0}}, in_delay_reg});
        thr_x   = CMP_W'($signed(threshold_reg));
        samp_x  = '0;
        any_cross = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            samp_x = CMP_W'(in_sample_reg[i]);
            if (samp_x >= thr_x) begin
                run_next[i] = (run_reg[i] == RUN_MAX) ? run_reg[i] : run_reg[i] + 1'b1;
            end else begin
                run_next[i] = '0;
            end
            if (run_next[i] > {1'b0, window_reg}) begin
                any_cross = 1'b1;
            end
        end
        ok = (ts >= ignore_until_reg) && (ts >= clear_until_reg);

        latch_next        = latch_reg;
        light_next        = light_reg;
        light_off_next    = light_off_reg;
        ignore_until_next = ignore_until_reg;
        clear_until_next  = clear_until_reg;
        fire_next         = fire_reg;

        if (in_action_reg) begin
            for (int i = 0; i < CHANNELS; i++) begin
                run_next[i] = '0;
            end
            any_cross         = 1'b0;
            latch_next        = 1'b0;
            light_next        = 1'b0;
            light_off_next    = NO_TIME;
            ignore_until_next = NO_TIME;
            fire_next         = NO_TIME;
            clear_until_next  = ts + $signed({{(TIME_W-CFG_W){1'b0}}, clear_ticks_reg});
        end else begin
            if (delay_en_reg) begin
                priority if (any_cross && ok && !latch_reg) begin
                    latch_next = 1'b1;
                    fire_next  = NO_TIME;
                end else if (latch_reg && !any_cross && ok) begin
                    latch_next = 1'b0;
                    fire_next  = ts + delay_t;
                end else if (!any_cross && !fire_reg[TIME_W-1] && ts >= fire_reg) begin
                    light_next        = 1'b1;
                    light_off_next    = ts + $signed({{(TIME_W-CFG_W){1'b0}}, light_ticks_reg});
                    ignore_until_next = ts + $signed({{(TIME_W-CFG_W){1'b0}},
                                                      ignore_ticks_reg});
                    fire_next         = NO_TIME;
                end else begin
                    latch_next = latch_reg;
                end
            end else begin
                priority if (any_cross && ok && !latch_reg) begin
                    latch_next        = 1'b1;
                    light_next        = 1'b1;
                    light_off_next    = ts + $signed({{(TIME_W-CFG_W){1'b0}}, light_ticks_reg});
                    ignore_until_next = ts + $signed({{(TIME_W-CFG_W){1'b0}},
                                                      ignore_ticks_reg});
                end else if (latch_reg && !any_cross) begin
                    latch_next = 1'b0;
                end else begin
                    latch_next = latch_reg;
                end
            end
            if (light_next && ts >= light_off_next) begin
                light_next     = 1'b0;
                light_off_next = NO_TIME;
            end
        end
        m_tdata_next = {{(OUT_W-3){1'b0}}, any_cross, latch_next, light_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                run_reg[i] <= '0;
            end
            latch_reg        <= 1'b0;
            light_reg        <= 1'b0;
            light_off_reg    <= NO_TIME;
            ignore_until_reg <= NO_TIME;
            clear_until_reg  <= NO_TIME;
            fire_reg         <= NO_TIME;
        end else if (proc) begin
            for (int i = 0; i < CHANNELS; i++) begin
                run_reg[i] <= run_next[i];
            end
            latch_reg        <= latch_next;
            light_reg        <= light_next;
            light_off_reg    <= light_off_next;
            ignore_until_reg <= ignore_until_next;
            clear_until_reg  <= clear_until_next;
            fire_reg         <= fire_next;
        end
    end

    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_action_reg |=> m_tvalid && m_tdata[2:0] == 3'b000)
        else $error("clear word gave a non-zero result");

    a_light_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        light_reg |-> light_off_reg != NO_TIME)
        else $error("light on without an off time");

    a_latch_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !in_action_reg && !delay_en_reg && !any_cross |=> !latch_reg)
        else $error("latch held without a crossing in direct mode");

    a_input_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

    a_result_match: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> m_tdata[1] == latch_reg && m_tdata[0] == light_reg)
        else $error("result word disagrees with state");

endmodule
`default_nettype wire

[tb/burst_triggered_light_switch_tb.sv]
// Testbench: burst_triggered_light_switch driven with directed and random words, checked by a scoreboard.
`timescale 1ns / 1ps
module burst_triggered_light_switch_tb;
    import btls_pkg::*;

    localparam int CHANNELS       = 4;
    localparam int SAMPLE_W       = 16;
    localparam int DELAY_LSB      = TS_W + CHANNELS * SAMPLE_W;
    localparam int S_TDATA_W      = ((DELAY_LSB + DELAY_W + 7) / 8) * 8;
    localparam int RANDOM_WORDS   = 330;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] REG_UNMAPPED = 3'd6;

    typedef struct packed {
        logic any_crossing;
        logic crossing_latched;
        logic light_on;
    } light_result_t;

    class light_switch_scoreboard;
        logic signed [15:0] threshold;
        logic [15:0]        window_count;
        logic [15:0]        light_ticks;
        logic [15:0]        ignore_ticks;
        logic [15:0]        clear_ticks;
        logic               delay_enable;
        logic [RUN_W-1:0]   run_count [CHANNELS];
        bit                 latched;
        bit                 light;
        longint             light_off_at;
        longint             ignore_until;
        longint             clear_until;
        longint             delay_fire_at;
        light_result_t      results_q [$];
        int                 errors;
        int                 results_seen;

        function new();
            threshold    = THRESHOLD_RST;
            window_count = WINDOW_COUNT_RST;
            light_ticks  = LIGHT_TICKS_RST;
            ignore_ticks = IGNORE_TICKS_RST;
            clear_ticks  = CLEAR_TICKS_RST;
            delay_enable = 1'b0;
            errors       = 0;
            results_seen = 0;
            clear_runs_and_timers();
            clear_until = -1;
        endfunction

        function void clear_runs_and_timers();
            foreach (run_count[i]) run_count[i] = '0;
            latched       = 0;
            light         = 0;
            light_off_at  = -1;
            ignore_until  = -1;
            delay_fire_at = -1;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_THRESHOLD:    threshold    = value[15:0];
                REG_WINDOW_COUNT: window_count = value[15:0];
                REG_LIGHT_TICKS:  light_ticks  = value[15:0];
                REG_IGNORE_TICKS: ignore_ticks = value[15:0];
                REG_CLEAR_TICKS:  clear_ticks  = value[15:0];
                REG_DELAY_ENABLE: delay_enable = value[0];
                default: ;
            endcase
        endfunction

        function void switch_on(longint t);
            light        = 1;
            light_off_at = t + longint'(light_ticks);
            ignore_until = t + longint'(ignore_ticks);
        endfunction

        function void note_word(logic [S_TDATA_W-1:0] data, logic action);
            longint             t;
            longint             dly;
            logic signed [15:0] smp;
            bit                 crossing;
            bit                 ok;
            light_result_t      r;
            t   = data[TS_W-1:0];
            dly = data[DELAY_LSB +: DELAY_W];
            if (action) begin
                clear_runs_and_timers();
                clear_until = t + longint'(clear_ticks);
                results_q.push_back('0);
                return;
            end
            crossing = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                smp = data[TS_W + SAMPLE_W*i +: SAMPLE_W];
                if (smp >= threshold) begin
                    if (run_count[i] < RUN_MAX) run_count[i]++;
                end else begin
                    run_count[i] = '0;
                end
                if (run_count[i] > window_count) crossing = 1;
            end
            ok = (t >= ignore_until) && (t >= clear_until);
            if (delay_enable) begin
                if (crossing && ok && !latched) begin
                    latched       = 1;
                    delay_fire_at = -1;
                end else if (latched && !crossing && ok) begin
                    latched       = 0;
                    delay_fire_at = t + dly;
                end else if (!crossing && delay_fire_at >= 0 && t >= delay_fire_at) begin
                    switch_on(t);
                    delay_fire_at = -1;
                end
            end else begin
                if (crossing && ok && !latched) begin
                    latched = 1;
                    switch_on(t);
                end else if (latched && !crossing) begin
                    latched = 0;
                end
            end
            if (light && t >= light_off_at) begin
                light        = 0;
                light_off_at = -1;
            end
            r.light_on         = light;
            r.crossing_latched = latched;
            r.any_crossing     = crossing;
            results_q.push_back(r);
        endfunction

        function void flag(string what, logic want, logic got);
            errors++;
            if (errors <= 10)
                $display("result %0d: %s expected %b, got %b", results_seen, what, want, got);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            light_result_t got;
            light_result_t want;
            got = data[2:0];
            results_seen++;
            if (results_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: %b arrived with nothing expected", results_seen, got);
                return;
            end
            want = results_q.pop_front();
            if (got.light_on !== want.light_on)
                flag("light_on", want.light_on, got.light_on);
            if (got.crossing_latched !== want.crossing_latched)
                flag("crossing_latched", want.crossing_latched, got.crossing_latched);
            if (got.any_crossing !== want.any_crossing)
                flag("any_crossing", want.any_crossing, got.any_crossing);
        endfunction

        function int pending();
            return results_q.size();
        endfunction

        function void close_out();
            if (results_q.size() != 0) begin
                $display("%0d results never arrived", results_q.size());
                errors += results_q.size();
            end
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_W-1:0]       m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    light_switch_scoreboard sb;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     stalled_cycles = 0;
    int                     cur_thr;
    int                     cur_win;
    logic [TS_W-1:0]        ts_now;

    burst_triggered_light_switch dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_word(s_tdata, s_tuser);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(logic [TS_W-1:0] ts,
                                                       logic [3:0][15:0] smp,
                                                       logic [DELAY_W-1:0] dly);
        return S_TDATA_W'({dly, smp, ts});
    endfunction

    function automatic logic [TS_W-1:0] next_ts();
        int     r;
        longint n;
        r = $urandom_range(99);
        n = ts_now;
        if (r < 70)
            n = n + 1;
        else if (r >= 80 && r < 95)
            n = n + $urandom_range(2, 40);
        else if (r >= 95 && r < 98)
            n = n + $urandom_range(41, 5000);
        else if (r >= 98)
            n = n - longint'($urandom_range(0, 50));
        if (n < 0) n = 0;
        if (n > 64'h7FFF_FFFF) n = 64'h7FFF_FFFF;
        ts_now = n[TS_W-1:0];
        return ts_now;
    endfunction

    function automatic logic [15:0] level_reaching();
        return 16'(cur_thr + int'($urandom_range(32767 - cur_thr)));
    endfunction

    function automatic logic [15:0] level_under();
        if (cur_thr == -32768) return 16'($urandom);
        return 16'(-32768 + int'($urandom_range(cur_thr + 32767)));
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        if ($urandom_range(1)) return DELAY_W'($urandom_range(0, 12));
        return DELAY_W'($urandom);
    endfunction

    task automatic send_word(logic action, logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= action;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_level(logic [TS_W-1:0] ts, logic [15:0] v, logic [DELAY_W-1:0] dly);
        send_word(1'b0, pack_word(ts, {v, v, v, v}, dly));
    endtask

    task automatic send_clear(logic [TS_W-1:0] ts);
        send_word(1'b1, pack_word(ts, {$urandom, $urandom}, DELAY_W'($urandom)));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic apply_settings(int k);
        logic [15:0] thr;
        logic [15:0] light;
        logic [15:0] ign;
        logic [15:0] clr;
        int          win;
        thr   = (k == 2) ? 16'h7FFF : (k == 4) ? 16'h8000 : 16'($urandom);
        win   = (k == 2) ? 0 : $urandom_range(0, 8);
        light = (k == 2) ? 16'd0 : (k == 3) ? 16'hFFFF : 16'($urandom_range(0, 60));
        ign   = (k == 2) ? 16'd0 : 16'($urandom_range(0, 80));
        clr   = (k == 2) ? 16'd0 : 16'($urandom_range(0, 80));
        cur_thr = int'($signed(thr));
        cur_win = win;
        write_reg(REG_THRESHOLD, 32'(thr));
        write_reg(REG_WINDOW_COUNT, 32'(win));
        write_reg(REG_LIGHT_TICKS, 32'(light));
        write_reg(REG_IGNORE_TICKS, 32'(ign));
        write_reg(REG_CLEAR_TICKS, 32'(clr));
        write_reg(REG_DELAY_ENABLE, 32'(k % 2));
    endtask

    task automatic run_bursts(int count);
        int               sent;
        int               r;
        int               len;
        int               gap;
        logic [3:0]       mask;
        logic [3:0][15:0] smp;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 4) begin
                send_clear(next_ts());
                sent++;
            end else if (r < 20) begin
                send_word(1'b0, pack_word(next_ts(), {$urandom, $urandom}, pick_delay()));
                sent++;
            end else begin
                mask = 4'($urandom_range(1, 15));
                len  = $urandom_range(0, ((cur_win > 12) ? 12 : cur_win) + 6);
                gap  = $urandom_range(1, 6);
                for (int j = 0; j < len + gap; j++) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (j >= len)
                            smp[c] = level_under();
                        else if (mask[c])
                            smp[c] = level_reaching();
                        else
                            smp[c] = 16'($urandom);
                    end
                    send_word(1'b0, pack_word(next_ts(), smp, pick_delay()));
                end
                sent += len + gap;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(REG_THRESHOLD, 32'hFFFB);
        write_reg(REG_WINDOW_COUNT, 32'd2);
        write_reg(REG_LIGHT_TICKS, 32'd3);
        write_reg(REG_IGNORE_TICKS, 32'd6);
        write_reg(REG_CLEAR_TICKS, 32'd4);
        write_reg(REG_DELAY_ENABLE, 32'd0);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);

        send_word(1'b0, pack_word(31'd0, {16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 12'd0));
        send_level(31'd1, 16'hFFFB, 12'hFFF);
        send_level(31'd2, 16'hFFFB, 12'd0);
        send_level(31'd3, 16'd0, 12'd0);
        send_level(31'd5, 16'd0, 12'd0);
        send_level(31'd6, 16'hFFFA, 12'd0);
        for (int t = 7; t <= 9; t++) send_level(31'(t), 16'd1, 12'd0);
        send_clear(31'd10);
        for (int t = 11; t <= 14; t++) send_level(31'(t), 16'd100, 12'd0);
        // step the time back
        send_level(31'd2, 16'd100, 12'd0);
        send_level(31'd3, 16'h8000, 12'd0);
        drain_results();

        // delayed switching, with a delay that fires at time zero
        write_reg(REG_DELAY_ENABLE, 32'd1);
        write_reg(REG_CLEAR_TICKS, 32'd0);
        send_clear(31'd0);
        for (int i = 0; i < 3; i++) send_level(31'd0, 16'd0, 12'd0);
        send_level(31'd0, 16'h8000, 12'd0);
        send_level(31'd0, 16'h8000, 12'd0);
        send_level(31'd5, 16'h8000, 12'd0);
        send_word(1'b0, pack_word(31'h7FFF_FFFF, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000},
                                  12'hFFF));
        drain_results();

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 19 : (p == 1) ? 88 : 0;
            recv_idle_pct = (p == 0) ? 88 : (p == 1) ? 19 : 0;
            for (int k = 0; k < 2; k++) begin
                drain_results();
                apply_settings(2 * p + k);
                ts_now = TS_W'($urandom_range(0, 32'h7FFF_0000));
                send_clear(ts_now);
                run_bursts(RANDOM_WORDS);
            end
        end

        drain_results();
        sb.close_out();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[burst_triggered_light_switch.f]
design/btls_pkg.sv
design/burst_triggered_light_switch.sv
tb/burst_triggered_light_switch_tb.sv
